>>> hdl/sip_pkg.sv
// Package for the speed interval propagator.
// Holds shared types, register indexes, status codes and reset values; no dependencies.
package sip_pkg;

   localparam int unsigned RegWidth = 24;
   localparam int unsigned NumRegs = 5;
   localparam int unsigned AddrWidth = 5;
   localparam int unsigned QueueDepth = 2;

   localparam logic [2:0] REG_VMAX = 3'd0;
   localparam logic [2:0] REG_WMAX = 3'd1;
   localparam logic [2:0] REG_ALAT = 3'd2;
   localparam logic [2:0] REG_ATAN = 3'd3;
   localparam logic [2:0] REG_AANG = 3'd4;

   localparam logic [23:0] VMAX_RESET = 24'd131072;
   localparam logic [23:0] WMAX_RESET = 24'd196608;
   localparam logic [23:0] ALAT_RESET = 24'd131072;
   localparam logic [23:0] ATAN_RESET = 24'd131072;
   localparam logic [23:0] AANG_RESET = 24'd262144;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FAIL = 2'd1;
   localparam logic [1:0] STATUS_DEAD = 2'd2;

   typedef struct packed {
      logic        route_start;
      logic [31:0] initial_min;
      logic [31:0] initial_max;
      logic [31:0] edge_length;
      logic [31:0] abs_curv;
      logic [31:0] endpoint_min;
      logic [31:0] endpoint_max;
      logic        stop_at_end;
      logic        bad_input;
   } edge_type;

   typedef struct packed {
      logic [23:0] vmax;
      logic [23:0] wmax;
      logic [23:0] alat;
      logic [23:0] atan;
      logic [23:0] aang;
   } cfg_type;

endpackage

>>> hdl/sip_front.sv
// Front end: takes input transfers, forms |k| and input checks, and queues edges.
// Depends on sip_pkg.
module sip_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  route_start,
   input  logic [31:0]           initial_min,
   input  logic [31:0]           initial_max,
   input  logic [31:0]           edge_length,
   input  logic signed [31:0]    edge_curvature,
   input  logic [31:0]           endpoint_min,
   input  logic [31:0]           endpoint_max,
   input  logic                  stop_at_end,
   output logic                  edge_valid,
   output sip_pkg::edge_type     edge_out,
   input  logic                  edge_take
);
   sip_pkg::edge_type q_ff [sip_pkg::QueueDepth];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   sip_pkg::edge_type item;
   logic do_push, do_pop;

   always_comb begin
      item.route_start = route_start;
      item.initial_min = initial_min;
      item.initial_max = initial_max;
      item.edge_length = edge_length;
      item.abs_curv = edge_curvature[31] ? (~edge_curvature + 32'd1) : edge_curvature;
      item.endpoint_min = endpoint_min;
      item.endpoint_max = endpoint_max;
      item.stop_at_end = stop_at_end;
      item.bad_input = (route_start && (initial_min > initial_max))
                       || (endpoint_min > endpoint_max) || (edge_length == 32'd0);
   end

   assign req_full = (cnt_ff == 2'd2);
   assign edge_valid = (cnt_ff != 2'd0);
   assign edge_out = q_ff[rp_ff];
   assign do_push = req_push && !req_full;
   assign do_pop = edge_take && edge_valid;
   assign wp_in = do_push ? ~wp_ff : wp_ff;
   assign rp_in = do_pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wp_ff] <= item;
      end
   end
endmodule

>>> hdl/sip_divider.sv
// Radix-2 restoring divider of a 48-bit dividend by a 32-bit divisor, one bit a cycle.
// Depends on nothing.
module sip_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);
   logic [47:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   assign trial = {r_ff[31:0], q_ff[47]} - {1'b0, divisor};
   assign done = busy_ff && (n_ff == 6'd1);
   assign quotient = {q_ff[46:0], ~trial[32]};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in = dividend;
         r_in = 33'd0;
         n_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[47]};
            q_in = {q_ff[46:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end
endmodule

>>> hdl/sip_back.sv
// Back end: sequencer of up to three divisions on one divider, caps and interval update.
// Depends on sip_pkg and sip_divider.
module sip_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              edge_valid,
   input  sip_pkg::edge_type edge_in,
   output logic              edge_take,
   input  sip_pkg::cfg_type  cfg,
   output logic              out_valid,
   output logic [31:0]       reach_min,
   output logic [31:0]       reach_max,
   output logic [1:0]        status,
   input  logic              out_take
);
   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_VSQ  = 10'b0000000010,
      S_DW   = 10'b0000000100,
      S_QSQ  = 10'b0000001000,
      S_DL   = 10'b0000010000,
      S_DA   = 10'b0000100000,
      S_CHK  = 10'b0001000000,
      S_MUL  = 10'b0010000000,
      S_FIN  = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   state_type st_ff, st_in;
   sip_pkg::edge_type e_ff;
   logic [31:0] cur_min_ff, cur_max_ff, imin_ff, imax_ff, cap_ff, acc_ff;
   logic [47:0] q_ff;
   logic [63:0] prod_ff;
   logic        dead_ff;
   logic [31:0] rmin_ff, rmax_ff;
   logic [1:0]  stat_ff;
   logic        div_start, div_done;
   logic [47:0] div_num, div_q;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [31:0] amax, delta, lo, hi, rmin, rmax, elo;
   logic [32:0] sum;
   logic        skip_dead, skip_fail;

   sip_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(e_ff.abs_curv), .done(div_done), .quotient(div_q)
   );

   assign mul_p = mul_a * mul_b;
   assign amax = (imax_ff < cap_ff) ? imax_ff : cap_ff;
   assign delta = (prod_ff[63:48] != 16'd0) ? 32'hFFFFFFFF : prod_ff[47:16];
   assign rmin = (imin_ff > delta) ? imin_ff - delta : 32'd0;
   assign sum = {1'b0, amax} + {1'b0, delta};
   assign rmax = (sum > {1'b0, cap_ff}) ? cap_ff : sum[31:0];
   assign skip_dead = dead_ff && !e_ff.route_start;
   assign skip_fail = e_ff.bad_input || (imin_ff > amax);
   assign edge_take = (st_ff == S_IDLE);
   assign out_valid = (st_ff == S_OUT);
   assign reach_min = rmin_ff;
   assign reach_max = rmax_ff;
   assign status = stat_ff;

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      div_num = 48'd0;
      div_start = 1'b0;
      st_in = st_ff;
      elo = e_ff.stop_at_end ? 32'd0
            : ((e_ff.endpoint_min == 32'd0) ? 32'd1 : e_ff.endpoint_min);
      lo = ((rmin < cap_ff) ? rmin : cap_ff);
      lo = (lo > elo) ? lo : elo;
      hi = (e_ff.endpoint_max < cap_ff) ? e_ff.endpoint_max : cap_ff;
      hi = (rmax < hi) ? rmax : hi;
      case (st_ff)
         S_IDLE: if (edge_valid) st_in = S_VSQ;
         S_VSQ: begin
            mul_a = {8'd0, cfg.vmax};
            mul_b = {8'd0, cfg.vmax};
            if (e_ff.abs_curv == 32'd0) begin
               st_in = S_CHK;
            end else begin
               div_num = {cfg.wmax, 24'd0};
               div_start = 1'b1;
               st_in = S_DW;
            end
         end
         S_DW: if (div_done) st_in = S_QSQ;
         S_QSQ: begin
            mul_a = q_ff[31:0];
            mul_b = q_ff[31:0];
            div_num = {cfg.alat, 24'd0};
            div_start = 1'b1;
            st_in = S_DL;
         end
         S_DL: if (div_done) begin
            div_num = {cfg.aang, 24'd0};
            div_start = 1'b1;
            st_in = S_DA;
         end
         S_DA: if (div_done) st_in = S_CHK;
         S_CHK: st_in = (skip_dead || skip_fail) ? S_OUT : S_MUL;
         S_MUL: begin
            mul_a = acc_ff;
            mul_b = e_ff.edge_length;
            st_in = S_FIN;
         end
         S_FIN: st_in = S_OUT;
         S_OUT: if (out_take) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         cur_min_ff <= 32'd0;
         cur_max_ff <= 32'd0;
         dead_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         case (st_ff)
            S_IDLE: if (edge_valid) begin
               e_ff <= edge_in;
               imin_ff <= edge_in.route_start ? edge_in.initial_min : cur_min_ff;
               imax_ff <= edge_in.route_start ? edge_in.initial_max : cur_max_ff;
               acc_ff <= {8'd0, cfg.atan};
               if (edge_in.route_start) dead_ff <= 1'b0;
            end
            S_VSQ: cap_ff <= mul_p[47:16];
            S_DW: if (div_done) q_ff <= div_q;
            S_QSQ: begin
               if (q_ff[47:32] != 16'd0 || mul_p[63:48] != 16'd0) begin
                  q_ff <= 48'hFFFFFFFF;
               end else begin
                  q_ff <= {16'd0, mul_p[47:16]};
               end
            end
            S_DL: if (div_done) begin
               if (q_ff[31:0] < cap_ff) cap_ff <= q_ff[31:0];
               q_ff <= div_q;
            end
            S_DA: if (div_done) begin
               if (q_ff[47:32] == 16'd0 && q_ff[31:0] < cap_ff) cap_ff <= q_ff[31:0];
               if (div_q[47:24] == 24'd0 && div_q[23:0] < acc_ff[23:0]) begin
                  acc_ff <= {8'd0, div_q[23:0]};
               end
            end
            S_CHK: begin
               if (skip_dead) begin
                  stat_ff <= sip_pkg::STATUS_DEAD;
               end else if (skip_fail) begin
                  stat_ff <= sip_pkg::STATUS_FAIL;
               end else begin
                  stat_ff <= sip_pkg::STATUS_OK;
               end
               rmin_ff <= 32'd0;
               rmax_ff <= 32'd0;
            end
            S_MUL: prod_ff <= {mul_p[62:0], 1'b0};
            S_FIN: begin
               if (mul_p[63] || lo > hi || (e_ff.stop_at_end && lo != 32'd0)) begin
                  stat_ff <= sip_pkg::STATUS_FAIL;
               end else begin
                  rmin_ff <= lo;
                  rmax_ff <= e_ff.stop_at_end ? 32'd0 : hi;
                  cur_min_ff <= lo;
                  cur_max_ff <= e_ff.stop_at_end ? 32'd0 : hi;
               end
            end
            S_OUT: if (stat_ff == sip_pkg::STATUS_FAIL) dead_ff <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

>>> hdl/speed_interval_propagator_unit.sv
// Top level of the speed interval propagator.
// Depends on sip_pkg, sip_front and sip_back.
//
// Edges enter on the req_ queue port (push/full) and one result per edge leaves on the
// rsp_ queue port (empty/pop), in order. Limits are set through the APB port; the user
// must set them only while the block is idle, as the block does not enforce this.
// Reads return the register values. A two-entry queue separates the front end from the
// back end, so further edges can be taken while the back end works. The back end
// handles one edge at a time. A straight edge skips the divider; a curved edge runs
// three divisions by |k| on one shared bit-serial divider. An edge that fails an input
// check skips the multiply and the interval update. The back end takes the next edge
// only once the last result is popped. A result is held until popped; while it waits,
// the back end stalls and the front queue fills, after which full is raised.
// Reset clears the queue, the interval to [0, 0], the failure flag, and restores
// the default limits.
module speed_interval_propagator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                req_route_start,
   input  logic [31:0]         req_initial_min,
   input  logic [31:0]         req_initial_max,
   input  logic [31:0]         req_edge_length,
   input  logic signed [31:0]  req_edge_curvature,
   input  logic [31:0]         req_endpoint_min,
   input  logic [31:0]         req_endpoint_max,
   input  logic                req_stop_at_end,
   output logic                empty,
   input  logic                pop,
   output logic [31:0]         rsp_reach_min,
   output logic [31:0]         rsp_reach_max,
   output logic [1:0]          rsp_status,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   sip_pkg::cfg_type  cfg_ff;
   sip_pkg::edge_type edge_q;
   logic edge_valid, edge_take, out_valid;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vmax <= sip_pkg::VMAX_RESET;
         cfg_ff.wmax <= sip_pkg::WMAX_RESET;
         cfg_ff.alat <= sip_pkg::ALAT_RESET;
         cfg_ff.atan <= sip_pkg::ATAN_RESET;
         cfg_ff.aang <= sip_pkg::AANG_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (idx)
            sip_pkg::REG_VMAX: cfg_ff.vmax <= pwdata[23:0];
            sip_pkg::REG_WMAX: cfg_ff.wmax <= pwdata[23:0];
            sip_pkg::REG_ALAT: cfg_ff.alat <= pwdata[23:0];
            sip_pkg::REG_ATAN: cfg_ff.atan <= pwdata[23:0];
            sip_pkg::REG_AANG: cfg_ff.aang <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         sip_pkg::REG_VMAX: prdata = {8'd0, cfg_ff.vmax};
         sip_pkg::REG_WMAX: prdata = {8'd0, cfg_ff.wmax};
         sip_pkg::REG_ALAT: prdata = {8'd0, cfg_ff.alat};
         sip_pkg::REG_ATAN: prdata = {8'd0, cfg_ff.atan};
         sip_pkg::REG_AANG: prdata = {8'd0, cfg_ff.aang};
         default: prdata = 32'd0;
      endcase
   end

   sip_front u_front (
      .clock(clock), .reset(reset), .req_push(push), .req_full(full),
      .route_start(req_route_start), .initial_min(req_initial_min),
      .initial_max(req_initial_max), .edge_length(req_edge_length),
      .edge_curvature(req_edge_curvature), .endpoint_min(req_endpoint_min),
      .endpoint_max(req_endpoint_max), .stop_at_end(req_stop_at_end),
      .edge_valid(edge_valid), .edge_out(edge_q), .edge_take(edge_take)
   );

   sip_back u_back (
      .clock(clock), .reset(reset), .edge_valid(edge_valid), .edge_in(edge_q),
      .edge_take(edge_take), .cfg(cfg_ff), .out_valid(out_valid),
      .reach_min(rsp_reach_min), .reach_max(rsp_reach_max), .status(rsp_status),
      .out_take(pop)
   );

   assign empty = !out_valid;
endmodule

>>> tb/sip_checker.sv
// Checker for the speed interval propagator: watches the edge, result and register ports.
// It predicts each result, compares it field by field and counts failures.
// Depends on sip_pkg.
module sip_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  logic               req_route_start,
   input  logic [31:0]        req_initial_min,
   input  logic [31:0]        req_initial_max,
   input  logic [31:0]        req_edge_length,
   input  logic signed [31:0] req_edge_curvature,
   input  logic [31:0]        req_endpoint_min,
   input  logic [31:0]        req_endpoint_max,
   input  logic               req_stop_at_end,
   input  logic               empty,
   input  logic               pop,
   input  logic [31:0]        rsp_reach_min,
   input  logic [31:0]        rsp_reach_max,
   input  logic [1:0]         rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 errors,
   output int                 pending
);
   typedef struct {
      logic [31:0] lo;
      logic [31:0] hi;
      logic [1:0]  status;
   } reach_type;

   localparam longint unsigned Sat = 64'hFFFF_FFFF;

   sip_pkg::cfg_type limits;
   logic [31:0] interval_min;
   logic [31:0] interval_max;
   logic route_failed;
   reach_type reach_queue[$];
   int error_count = 0;

   assign errors = error_count;

   function automatic longint unsigned lmin(longint unsigned a, longint unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic longint unsigned lmax(longint unsigned a, longint unsigned b);
      return a > b ? a : b;
   endfunction

   function automatic reach_type propagate_edge(logic start, logic [31:0] imin_in,
         logic [31:0] imax_in, logic [31:0] len_in, logic [31:0] curv,
         logic [31:0] emin_in, logic [31:0] emax_in, logic term);
      reach_type r;
      longint unsigned imin, imax, len, emin, emax, ak, cap, q, w2, lat, acc;
      longint unsigned delta, amax, rmin, rmax, lo, hi;
      r.lo = '0;
      r.hi = '0;
      r.status = sip_pkg::STATUS_FAIL;
      len = len_in;
      emin = emin_in;
      emax = emax_in;
      if (start) begin
         route_failed = 1'b0;
         imin = imin_in;
         imax = imax_in;
      end else begin
         if (route_failed) begin
            r.status = sip_pkg::STATUS_DEAD;
            return r;
         end
         imin = interval_min;
         imax = interval_max;
      end
      ak = curv[31] ? ((~{32'd0, curv}) + 64'd1) & Sat : {32'd0, curv};
      if (imin > imax || emin > emax || len == 0) begin
         route_failed = 1'b1;
         return r;
      end
      cap = (longint'(limits.vmax) * longint'(limits.vmax)) >> 16;
      acc = limits.atan;
      if (ak != 0) begin
         q = ({40'd0, limits.wmax} << 24) / ak;
         w2 = (q >= 64'h1_0000_0000) ? Sat : lmin((q * q) >> 16, Sat);
         lat = lmin(({40'd0, limits.alat} << 24) / ak, Sat);
         cap = lmin(lmin(cap, w2), lat);
         acc = lmin(acc, ({40'd0, limits.aang} << 24) / ak);
      end
      amax = lmin(imax, cap);
      if (imin > amax) begin
         route_failed = 1'b1;
         return r;
      end
      delta = lmin((2 * acc * len) >> 16, Sat);
      rmin = imin > delta ? imin - delta : 0;
      rmin = lmin(rmin, cap);
      rmax = lmin(amax + delta, cap);
      lo = lmax(rmin, term ? 0 : lmax(emin, 1));
      hi = lmin(rmax, lmin(emax, cap));
      if (lo > hi || (term && lo != 0)) begin
         route_failed = 1'b1;
         return r;
      end
      if (term) hi = 0;
      interval_min = lo[31:0];
      interval_max = hi[31:0];
      r.lo = lo[31:0];
      r.hi = hi[31:0];
      r.status = sip_pkg::STATUS_OK;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      reach_type want;
      if (reset) begin
         limits <= '{sip_pkg::VMAX_RESET, sip_pkg::WMAX_RESET, sip_pkg::ALAT_RESET,
                     sip_pkg::ATAN_RESET, sip_pkg::AANG_RESET};
         interval_min = '0;
         interval_max = '0;
         route_failed = 1'b0;
         reach_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               sip_pkg::REG_VMAX: limits.vmax <= pwdata[23:0];
               sip_pkg::REG_WMAX: limits.wmax <= pwdata[23:0];
               sip_pkg::REG_ALAT: limits.alat <= pwdata[23:0];
               sip_pkg::REG_ATAN: limits.atan <= pwdata[23:0];
               sip_pkg::REG_AANG: limits.aang <= pwdata[23:0];
               default: ;
            endcase
         end
         if (push && !full)
            reach_queue = {reach_queue, propagate_edge(req_route_start, req_initial_min,
               req_initial_max, req_edge_length, req_edge_curvature, req_endpoint_min,
               req_endpoint_max, req_stop_at_end)};
         if (pop && !empty) begin
            if (reach_queue.size() == 0) begin
               $display("result transfer with no edge outstanding");
               error_count++;
            end else begin
               want = reach_queue.pop_front();
               if (rsp_reach_min !== want.lo)
                  report_mismatch("reach_min", rsp_reach_min, want.lo);
               if (rsp_reach_max !== want.hi)
                  report_mismatch("reach_max", rsp_reach_max, want.hi);
               if (rsp_status !== want.status)
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
            end
         end
      end
      pending = reach_queue.size();
   end
endmodule

>>> tb/tb.sv
// Top of the speed interval propagator testbench: clock, reset, edge and register stimulus.
// Depends on sip_pkg, speed_interval_propagator_unit and sip_checker.
module tb;
   localparam int WatchdogLimit = 4000;

   typedef struct {
      logic        start;
      logic [31:0] imin;
      logic [31:0] imax;
      logic [31:0] len;
      logic [31:0] curv;
      logic [31:0] emin;
      logic [31:0] emax;
      logic        term;
   } route_edge_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_route_start = 1'b0;
   logic [31:0] req_initial_min = '0;
   logic [31:0] req_initial_max = '0;
   logic [31:0] req_edge_length = '0;
   logic signed [31:0] req_edge_curvature = '0;
   logic [31:0] req_endpoint_min = '0;
   logic [31:0] req_endpoint_max = '0;
   logic req_stop_at_end = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic [31:0] rsp_reach_min;
   logic [31:0] rsp_reach_max;
   logic [1:0] rsp_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   int errors;
   int pending;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   speed_interval_propagator_unit u_dut (.*);

   sip_checker u_checker (.*);

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The result side takes each transfer after a random wait, or at once while gaps are off.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   task automatic write_limit(logic [2:0] index, logic [23:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {8'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_until_drained();
      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_edge(route_edge_type e);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_route_start <= e.start;
      req_initial_min <= e.imin;
      req_initial_max <= e.imax;
      req_edge_length <= e.len;
      req_edge_curvature <= e.curv;
      req_endpoint_min <= e.emin;
      req_endpoint_max <= e.emax;
      req_stop_at_end <= e.term;
      do @(posedge clock); while (full);
   endtask

   function automatic route_edge_type make_edge(logic start, logic [31:0] len,
         logic [31:0] curv, logic [31:0] emin, logic [31:0] emax, logic term);
      route_edge_type e;
      e.start = start;
      e.imin = 32'd0;
      e.imax = 32'h0002_0000;
      e.len = len;
      e.curv = curv;
      e.emin = emin;
      e.emax = emax;
      e.term = term;
      return e;
   endfunction

   function automatic route_edge_type random_edge(logic start, logic term);
      route_edge_type e;
      e.start = start;
      e.imin = $urandom_range(0, 32'h0002_0000);
      e.imax = e.imin + $urandom_range(0, 32'h0004_0000);
      e.len = $urandom_range(1, 32'h0003_0000);
      case ($urandom_range(0, 3))
         0: e.curv = 32'd0;
         1: e.curv = $urandom_range(0, 32'h0200_0000);
         2: e.curv = -$urandom_range(1, 32'h0200_0000);
         default: e.curv = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
      e.emin = $urandom_range(0, 32'h0002_0000);
      e.emax = e.emin + $urandom_range(0, 32'h0006_0000);
      e.term = term;
      if ($urandom_range(0, 9) == 0) begin
         e.imin = $urandom;
         e.imax = $urandom;
         e.len = $urandom;
         e.curv = $urandom;
         e.emin = $urandom;
         e.emax = $urandom;
         e.term = 1'($urandom_range(0, 1));
      end
      return e;
   endfunction

   task automatic set_limits(logic [23:0] vmax, logic [23:0] wmax, logic [23:0] alat,
         logic [23:0] atan, logic [23:0] aang);
      wait_until_drained();
      write_limit(sip_pkg::REG_VMAX, vmax);
      write_limit(sip_pkg::REG_WMAX, wmax);
      write_limit(sip_pkg::REG_ALAT, alat);
      write_limit(sip_pkg::REG_ATAN, atan);
      write_limit(sip_pkg::REG_AANG, aang);
   endtask

   initial begin
      int route_len;
      int sent;
      route_edge_type e;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edges at the field extremes and through the failure paths.
      send_edge(make_edge(1'b1, 32'h0001_0000, 32'd0, 32'd0, 32'h0004_0000, 1'b0));
      send_edge(make_edge(1'b0, 32'h0001_0000, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 1'b0));
      send_edge(make_edge(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0));
      send_edge(make_edge(1'b1, 32'h0000_8000, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0));
      send_edge(make_edge(1'b0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0));
      send_edge(make_edge(1'b1, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0));
      send_edge(make_edge(1'b0, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0));
      e = make_edge(1'b1, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0);
      e.imin = 32'h0003_0000;
      send_edge(e);
      send_edge(make_edge(1'b1, 32'h0001_0000, 32'd0, 32'h0002_0000, 32'h0001_0000, 1'b0));
      send_edge(make_edge(1'b1, 32'h0000_1000, 32'h0100_0000, 32'd0, 32'h0004_0000, 1'b1));
      e = make_edge(1'b1, 32'h0000_0100, 32'd0, 32'd0, 32'h0004_0000, 1'b1);
      e.imin = 32'h0002_0000;
      send_edge(e);
      e = make_edge(1'b1, 32'h0001_0000, 32'hFF00_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
      e.imin = 32'hFFFF_FFFF;
      e.imax = 32'hFFFF_FFFF;
      send_edge(e);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: ;
            1: set_limits(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
            2: set_limits(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
            3: set_limits(24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
            default: set_limits(24'($urandom), 24'($urandom_range(0, 24'h08_0000)),
                     24'($urandom_range(0, 24'h08_0000)), 24'($urandom), 24'($urandom));
         endcase
         no_gaps = (phase == 5);
         sent = 0;
         while (sent < 200) begin
            route_len = $urandom_range(1, 8);
            for (int i = 0; i < route_len; i++) begin
               send_edge(random_edge(i == 0 || $urandom_range(0, 19) == 0,
                         i == route_len - 1 && $urandom_range(0, 1)));
               sent++;
            end
         end
      end
      wait_until_drained();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
